// File: sv/lmqs_pkg.sv
`timescale 1ns / 1ps

package lmqs_pkg;

  // Fixed panel geometry
  localparam int BUFFER_ROWS     = 64;
  localparam int SCAN_ROW_COUNT  = 4;
  localparam int BAND_ROWS       = 16;
  localparam int DEF_WIDTH_BYTES = 8;
  localparam int CMD_COL_W       = 5;   // holds a column index for widths up to 32 bytes

  // Register indexes
  localparam logic [1:0] REG_WIDTH_BYTES = 2'd0;
  localparam logic [1:0] REG_ON_TICKS    = 2'd1;
  localparam logic [1:0] REG_OFF_TICKS   = 2'd2;

  // Register reset values
  localparam logic [3:0] RST_WIDTH_BYTES = 4'd8;
  localparam logic [7:0] RST_ON_TICKS    = 8'd2;
  localparam logic [7:0] RST_OFF_TICKS   = 8'd3;

  // Operation codes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  typedef enum logic [1:0] {
    PH_SHIFT,
    PH_LATCH,
    PH_ON,
    PH_OFF
  } lmqs_phase_t;

  typedef struct packed {
    logic       operation;
    logic [5:0] buffer_row;
    logic [2:0] column_byte;
    logic [7:0] red_byte;
    logic [7:0] green_byte;
  } lmqs_in_t;

  typedef struct packed {
    logic [3:0] red_lines;
    logic [3:0] green_lines;
    logic       shift_clock;
    logic [1:0] row_address;
    logic       latch_pulse;
    logic       output_enable;
  } lmqs_out_t;

  // Classified word passed from the sequencer to the buffer side
  typedef struct packed {
    logic                 is_tick;
    logic                 wr_en;       // write with an in-range column
    logic [5:0]           row;         // write row, or band-relative read row in [3:0]
    logic [CMD_COL_W-1:0] col;
    logic [7:0]           red;
    logic [7:0]           green;
    logic                 shift;
    logic                 latch;
    logic                 oe;
    logic [1:0]           row_addr;
    logic [2:0]           bit_idx;
  } lmqs_cmd_t;

endpackage

// File: sv/lmqs_front.sv
`timescale 1ns / 1ps

module lmqs_front import lmqs_pkg::*; #(
  parameter int MAX_WIDTH_BYTES = DEF_WIDTH_BYTES
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write_en,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       accept,
  input  lmqs_in_t   req,
  output lmqs_cmd_t  cmd
);

  localparam int COL_W = (MAX_WIDTH_BYTES > 1) ? $clog2(MAX_WIDTH_BYTES) : 1;
  localparam int EW_W  = (COL_W + 1 > 4) ? COL_W + 1 : 4;
  localparam logic [EW_W-1:0] MAX_W = EW_W'(MAX_WIDTH_BYTES);

  logic [3:0] width_bytes;
  logic [7:0] on_ticks;
  logic [7:0] off_ticks;

  lmqs_phase_t      phase, phase_next;
  logic [1:0]       scan_row, scan_row_next;
  logic [COL_W-1:0] column_count, column_count_next;
  logic [1:0]       group_count, group_count_next;
  logic [2:0]       bit_count, bit_count_next;
  logic [7:0]       phase_timer, phase_timer_next;

  logic [EW_W-1:0] width_ext, eff_width;
  logic            col_last, on_done, off_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_bytes <= RST_WIDTH_BYTES;
      on_ticks    <= RST_ON_TICKS;
      off_ticks   <= RST_OFF_TICKS;
    end else if (cfg_write_en) begin
      case (cfg_index)
        REG_WIDTH_BYTES: width_bytes <= cfg_data[3:0];
        REG_ON_TICKS:    on_ticks    <= cfg_data;
        REG_OFF_TICKS:   off_ticks   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Width clamp: zero acts as one, oversize acts as the buffer width
  always_comb begin
    width_ext = EW_W'(width_bytes);
    if (width_ext == '0)        eff_width = EW_W'(1);
    else if (width_ext > MAX_W) eff_width = MAX_W;
    else                        eff_width = width_ext;
  end

  assign col_last = (EW_W'(column_count) + EW_W'(1)) >= eff_width;
  assign on_done  = ({1'b0, phase_timer} + 9'd1) >= {1'b0, on_ticks};
  assign off_done = ({1'b0, phase_timer} + 9'd1) >= {1'b0, off_ticks};

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_SHIFT;
      scan_row     <= '0;
      column_count <= '0;
      group_count  <= '0;
      bit_count    <= '0;
      phase_timer  <= '0;
    end else if (accept && req.operation == OP_TICK) begin
      phase        <= phase_next;
      scan_row     <= scan_row_next;
      column_count <= column_count_next;
      group_count  <= group_count_next;
      bit_count    <= bit_count_next;
      phase_timer  <= phase_timer_next;
    end
  end

  always_comb begin
    phase_next        = phase;
    scan_row_next     = scan_row;
    column_count_next = column_count;
    group_count_next  = group_count;
    bit_count_next    = bit_count;
    phase_timer_next  = phase_timer;

    cmd          = '0;
    cmd.is_tick  = (req.operation == OP_TICK);
    cmd.row_addr = scan_row;
    cmd.bit_idx  = bit_count;
    cmd.red      = req.red_byte;
    cmd.green    = req.green_byte;

    if (req.operation == OP_WRITE) begin
      cmd.wr_en = (int'(req.column_byte) < MAX_WIDTH_BYTES);
      cmd.row   = req.buffer_row;
      cmd.col   = CMD_COL_W'(req.column_byte);
    end else begin
      case (phase)
        PH_SHIFT: begin
          cmd.shift = 1'b1;
          // group offset 12 - 4*g is {~g, 2'b00}
          cmd.row   = {2'b00, ~group_count, scan_row};
          cmd.col   = CMD_COL_W'(column_count);
          bit_count_next = bit_count + 3'd1;
          if (bit_count == 3'd7) begin
            group_count_next = group_count + 2'd1;
            if (group_count == 2'd3) begin
              if (col_last) begin
                column_count_next = '0;
                phase_next        = PH_LATCH;
              end else begin
                column_count_next = column_count + COL_W'(1);
              end
            end
          end
        end
        PH_LATCH: begin
          cmd.latch        = 1'b1;
          phase_next       = PH_ON;
          phase_timer_next = '0;
        end
        PH_ON: begin
          cmd.oe = 1'b1;
          if (on_done) begin
            phase_timer_next = '0;
            if (off_ticks == '0) begin
              phase_next    = PH_SHIFT;
              scan_row_next = scan_row + 2'd1;
            end else begin
              phase_next = PH_OFF;
            end
          end else begin
            phase_timer_next = phase_timer + 8'd1;
          end
        end
        default: begin
          if (off_done) begin
            phase_next       = PH_SHIFT;
            scan_row_next    = scan_row + 2'd1;
            phase_timer_next = '0;
          end else begin
            phase_timer_next = phase_timer + 8'd1;
          end
        end
      endcase
    end
  end

endmodule

// File: sv/lmqs_queue.sv
`timescale 1ns / 1ps

module lmqs_queue import lmqs_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  lmqs_cmd_t push_cmd,
  output logic      full,
  input  logic      pop,
  output logic      head_valid,
  output lmqs_cmd_t head
);

  lmqs_cmd_t  slots [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: sv/lmqs_back.sv
`timescale 1ns / 1ps

module lmqs_back import lmqs_pkg::*; #(
  parameter int MAX_WIDTH_BYTES = DEF_WIDTH_BYTES
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      head_valid,
  input  lmqs_cmd_t head,
  output logic      pop,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output lmqs_out_t rsp
);

  localparam int COL_W      = (MAX_WIDTH_BYTES > 1) ? $clog2(MAX_WIDTH_BYTES) : 1;
  localparam int ADDR_W     = 4 + COL_W;
  localparam int BANK_DEPTH = 1 << ADDR_W;

  logic [ADDR_W-1:0] addr;
  logic              rd_en;
  logic [15:0]       rd_q [4];

  logic        s1_valid;
  logic        s1_shift, s1_latch, s1_oe;
  logic [1:0]  s1_row_addr;
  logic [2:0]  s1_bit_idx;
  logic        out_free, s1_free;
  lmqs_out_t   res;

  assign addr     = {head.row[3:0], head.col[COL_W-1:0]};
  assign out_free = !rsp_valid || !rsp_stall;
  assign s1_free  = !s1_valid || out_free;
  assign pop      = head_valid && (!head.is_tick || s1_free);
  assign rd_en    = pop && head.is_tick;

  // One bank per 16-row band so the four band rows read in parallel
  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [15:0] mem [BANK_DEPTH];
    always_ff @(posedge clk) begin
      if (pop && !head.is_tick && head.wr_en && head.row[5:4] == 2'(b))
        mem[addr] <= {head.red, head.green};
      if (rd_en)
        rd_q[b] <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (rd_en) begin
      s1_valid <= 1'b1;
    end else if (out_free) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      s1_shift    <= head.shift;
      s1_latch    <= head.latch;
      s1_oe       <= head.oe;
      s1_row_addr <= head.row_addr;
      s1_bit_idx  <= head.bit_idx;
    end
  end

  // MSB first: bit index n picks bit 7-n (red in the upper byte)
  always_comb begin
    res = '0;
    for (int k = 0; k < 4; k++) begin
      res.red_lines[k]   = s1_shift & rd_q[k][{1'b1, ~s1_bit_idx}];
      res.green_lines[k] = s1_shift & rd_q[k][{1'b0, ~s1_bit_idx}];
    end
    res.shift_clock   = s1_shift;
    res.row_address   = s1_row_addr;
    res.latch_pulse   = s1_latch;
    res.output_enable = s1_oe;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (out_free) begin
      rsp_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_valid) rsp <= res;
  end

endmodule

// File: sv/led_matrix_quarter_scan_driver.sv
`timescale 1ns / 1ps

// Two-color quarter-scan LED panel driver.
// Request channel (req_valid / req_stall / req): a word is either a frame
// buffer write (one red and one green byte at buffer_row, column_byte) or
// one scan tick. Writes give no response; every tick gives exactly one
// response word on rsp_valid / rsp_stall / rsp carrying the panel pins:
// four red and four green data lines, shift clock, row address A/B,
// latch strobe and output enable.
// Config: cfg_write_en writes cfg_data into register cfg_index
// (0 width_bytes, 1 on_ticks, 2 off_ticks); change it only while idle.
// Throughput: one word per cycle while req_stall is low. The sequencer
// classifies each tick as it is accepted; a two-entry queue feeds the
// buffer side, where four banked buffer memories (one per 16-row band)
// are read in parallel into the read registers ahead of the response
// register. A write is visible to any tick accepted after it.
// Reset: sequencer restarts at scan row 0 in the shift phase, registers
// return to 8 / 2 / 3, buffer contents are left as they are.
// Receiver stall: the response register holds; the buffer side backs up
// into the queue, and req_stall rises once the queue holds two words.
module led_matrix_quarter_scan_driver import lmqs_pkg::*; #(
  parameter int MAX_WIDTH_BYTES = DEF_WIDTH_BYTES
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write_en,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       req_valid,
  output logic       req_stall,
  input  lmqs_in_t   req,
  output logic       rsp_valid,
  input  logic       rsp_stall,
  output lmqs_out_t  rsp
);

  logic      accept;
  logic      q_full;
  logic      q_pop;
  logic      q_valid;
  lmqs_cmd_t front_cmd;
  lmqs_cmd_t q_head;

  assign req_stall = q_full;
  assign accept    = req_valid && !q_full;

  // Sequencer and register file: classifies each word as it is accepted
  lmqs_front #(
    .MAX_WIDTH_BYTES(MAX_WIDTH_BYTES)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .accept       (accept),
    .req          (req),
    .cmd          (front_cmd)
  );

  // Decouples the sequencer from the buffer/output side
  lmqs_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (accept),
    .push_cmd   (front_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head       (q_head)
  );

  // Frame buffers, bit select and response register
  lmqs_back #(
    .MAX_WIDTH_BYTES(MAX_WIDTH_BYTES)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (q_valid),
    .head       (q_head),
    .pop        (q_pop),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .rsp        (rsp)
  );

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps

// Quarter-scan panel driver testbench.
// Sender pushes buffer-write and scan-tick words on req; every tick must
// come back as exactly one pin word on rsp. A local model of the scan
// sequencer predicts the pin word at the moment each tick is accepted,
// and a checker pops those predictions in order as rsp words arrive.
module tb import lmqs_pkg::*;;

  localparam int MAX_W       = DEF_WIDTH_BYTES;
  localparam int FRAME_BYTES = BUFFER_ROWS * MAX_W;
  localparam int CYCLE_LIMIT = 300000;

  logic       clk;
  logic       rst          = 1'b1;
  logic       cfg_write_en = 1'b0;
  logic [1:0] cfg_index    = REG_WIDTH_BYTES;
  logic [7:0] cfg_data     = '0;
  logic       req_valid    = 1'b0;
  logic       req_stall;
  lmqs_in_t   req          = '0;
  logic       rsp_valid;
  logic       rsp_stall    = 1'b0;
  lmqs_out_t  rsp;

  led_matrix_quarter_scan_driver u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .req          (req),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .rsp          (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------
  // Panel model: frame buffers, sequencer state, register copies
  // ---------------------------------------------------------------
  logic [7:0]  frame_red   [FRAME_BYTES];
  logic [7:0]  frame_green [FRAME_BYTES];
  logic [1:0]  scan_row    = '0;
  logic [2:0]  col_idx     = '0;
  logic [1:0]  group_idx   = '0;
  logic [2:0]  bit_idx     = '0;
  lmqs_phase_t seq_phase   = PH_SHIFT;
  logic [7:0]  phase_ticks = '0;
  logic [3:0]  width_cfg   = RST_WIDTH_BYTES;
  logic [7:0]  on_cfg      = RST_ON_TICKS;
  logic [7:0]  off_cfg     = RST_OFF_TICKS;

  lmqs_out_t pin_queue[$];     // predicted pin words, oldest first
  lmqs_out_t want;
  int        mismatch_count = 0;
  int        cycle_count    = 0;
  bit        no_idle        = 1'b0;  // set for the tail: no gaps, no stalls
  int        stall_left     = 0;

  function automatic void advance_scan_row();
    scan_row    = scan_row + 1'b1;
    seq_phase   = PH_SHIFT;
    phase_ticks = '0;
  endfunction

  // Pins for one scan tick; steps the sequencer as a side effect.
  function automatic lmqs_out_t panel_pins_for_tick();
    lmqs_out_t pins;
    int        base;
    int        addr;
    int        eff_w;
    int        k;
    pins = '0;
    pins.row_address = scan_row;
    // width 0 behaves as 1, anything past the buffer width clamps
    eff_w = (width_cfg == 0) ? 1 : ((int'(width_cfg) > MAX_W) ? MAX_W : int'(width_cfg));
    case (seq_phase)
      PH_SHIFT: begin
        // groups walk offsets 12, 8, 4, 0; bands sit 16 rows apart
        base = 12 - 4 * int'(group_idx) + int'(scan_row);
        for (k = 0; k < 4; k++) begin
          addr = ((base + BAND_ROWS * k) % BUFFER_ROWS) * MAX_W + int'(col_idx);
          pins.red_lines[k]   = frame_red[addr][7 - int'(bit_idx)];
          pins.green_lines[k] = frame_green[addr][7 - int'(bit_idx)];
        end
        pins.shift_clock = 1'b1;
        bit_idx = bit_idx + 1'b1;
        if (bit_idx == 0) begin
          group_idx = group_idx + 1'b1;
          if (group_idx == 0) begin
            // a shrunk width ends the row at the next column boundary
            if (int'(col_idx) + 1 >= eff_w) begin
              col_idx   = '0;
              seq_phase = PH_LATCH;
            end else begin
              col_idx = col_idx + 1'b1;
            end
          end
        end
      end
      PH_LATCH: begin
        pins.latch_pulse = 1'b1;
        seq_phase        = PH_ON;
        phase_ticks      = '0;
      end
      PH_ON: begin
        pins.output_enable = 1'b1;
        // on_ticks 0 still yields one lit tick
        if (int'(phase_ticks) + 1 >= int'(on_cfg)) begin
          if (off_cfg == 0) begin
            advance_scan_row();
          end else begin
            seq_phase   = PH_OFF;
            phase_ticks = '0;
          end
        end else begin
          phase_ticks = phase_ticks + 1'b1;
        end
      end
      default: begin
        if (int'(phase_ticks) + 1 >= int'(off_cfg)) advance_scan_row();
        else phase_ticks = phase_ticks + 1'b1;
      end
    endcase
    return pins;
  endfunction

  // ---------------------------------------------------------------
  // Word builders
  // ---------------------------------------------------------------
  function automatic lmqs_in_t write_word(int row, int col, logic [7:0] r, logic [7:0] g);
    lmqs_in_t w;
    w.operation   = OP_WRITE;
    w.buffer_row  = row[5:0];
    w.column_byte = col[2:0];
    w.red_byte    = r;
    w.green_byte  = g;
    return w;
  endfunction

  // random words; tick words carry random junk in the address and data fields
  function automatic lmqs_in_t random_word(logic op);
    lmqs_in_t w;
    w = write_word($urandom_range(0, BUFFER_ROWS - 1), $urandom_range(0, MAX_W - 1),
                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    w.operation = op;
    return w;
  endfunction

  // ---------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------
  // Caller sits just after a rising edge. Optional idle burst, then the
  // word is held until accepted; the prediction is made at acceptance.
  task automatic send_word(input lmqs_in_t w);
    if (!no_idle && $urandom_range(0, 15) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    req       <= w;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    if (w.operation == OP_TICK) begin
      pin_queue.push_back(panel_pins_for_tick());
    end else begin
      frame_red[int'(w.buffer_row) * MAX_W + int'(w.column_byte)]   = w.red_byte;
      frame_green[int'(w.buffer_row) * MAX_W + int'(w.column_byte)] = w.green_byte;
    end
  endtask

  // Stop sending, let every outstanding pin word come back, and give a
  // write still in flight time to land.
  task automatic wait_idle();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pin_queue.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_data     <= data;
    @(posedge clk);
    case (idx)
      REG_WIDTH_BYTES: width_cfg = data[3:0];
      REG_ON_TICKS:    on_cfg    = data;
      REG_OFF_TICKS:   off_cfg   = data;
      default: ;
    endcase
  endtask

  // Registers change only with the pipe empty; the sequencer keeps its
  // position, so new values can land mid-row or mid-phase.
  task automatic apply_setting(input logic [7:0] w, input logic [7:0] on_t,
                               input logic [7:0] off_t);
    wait_idle();
    write_reg(REG_WIDTH_BYTES, w);
    write_reg(REG_ON_TICKS, on_t);
    write_reg(REG_OFF_TICKS, off_t);
    cfg_write_en <= 1'b0;
  endtask

  // Mostly ticks, with buffer rewrites sprinkled in.
  task automatic run_mixed(input int count);
    int i;
    for (i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < 85) send_word(random_word(OP_TICK));
      else send_word(random_word(OP_WRITE));
    end
  endtask

  // ---------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------
  // Whole buffer gets written before the first tick, so no read ever
  // touches an unwritten byte.
  task automatic test_fill_frame();
    int r;
    int c;
    for (r = 0; r < BUFFER_ROWS; r++)
      for (c = 0; c < MAX_W; c++)
        send_word(write_word(r, c, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255))));
  endtask

  // Reset settings (width 8). Scan row 0, column 0 first reads rows
  // 12/28/44/60, then 8/24/40/56; plant edge patterns there.
  task automatic test_directed_patterns();
    int i;
    send_word(write_word(12, 0, 8'h00, 8'hFF));
    send_word(write_word(28, 0, 8'hFF, 8'h00));
    send_word(write_word(44, 0, 8'h80, 8'h01));
    send_word(write_word(60, 0, 8'h01, 8'h80));
    for (i = 0; i < 8; i++) send_word(random_word(OP_TICK));
    // rewrite rows just before the next group reads them
    send_word(write_word(8, 0, 8'h5A, 8'hA5));
    send_word(write_word(56, 0, 8'hFF, 8'hFF));
    for (i = 0; i < 8; i++) send_word(random_word(OP_TICK));
    // corners of the buffer
    send_word(write_word(0, 0, 8'hFF, 8'h00));
    send_word(write_word(63, 7, 8'h00, 8'hFF));
    send_word(write_word(0, 7, 8'h00, 8'h00));
    send_word(write_word(63, 0, 8'hFF, 8'hFF));
  endtask

  // Register sweep, extremes included: width 0 and past range, zero on
  // time, zero and maximum blanking, maximum on time.
  task automatic test_scan_settings();
    apply_setting(8'd1, 8'd1, 8'd0);
    run_mixed(40);
    apply_setting(8'd0, 8'd0, 8'd1);
    run_mixed(30);
    apply_setting(8'd1, 8'd255, 8'd0);
    run_mixed(220);
    apply_setting(8'd1, 8'd0, 8'd255);
    run_mixed(220);
    apply_setting(8'd3, 8'd5, 8'd7);
    run_mixed(30);
    apply_setting(8'd15, 8'd2, 8'd3);
    run_mixed(30);
    apply_setting(8'd2, 8'($urandom_range(0, 15)), 8'($urandom_range(0, 15)));
    run_mixed(30);
  endtask

  // Back to back traffic, no stalls on either side.
  task automatic test_quiet_tail();
    apply_setting(8'd9, 8'd3, 8'd1);
    no_idle = 1'b1;
    run_mixed(60);
  endtask

  // ---------------------------------------------------------------
  // Response side: random stall bursts
  always @(posedge clk) begin
    if (stall_left != 0) begin
      rsp_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (!no_idle && $urandom_range(0, 19) == 0) begin
      rsp_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 14);
    end else begin
      rsp_stall <= 1'b0;
    end
  end

  // Checker: compare each accepted pin word with the oldest prediction
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pin_queue.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected pin word: r %h g %h clk %b row %0d lat %b oe %b",
                   rsp.red_lines, rsp.green_lines, rsp.shift_clock, rsp.row_address,
                   rsp.latch_pulse, rsp.output_enable);
      end else begin
        want = pin_queue.pop_front();
        if (rsp !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $write("pin mismatch at %0t: exp r %h g %h clk %b row %0d lat %b oe %b,",
                   $realtime, want.red_lines, want.green_lines, want.shift_clock,
                   want.row_address, want.latch_pulse, want.output_enable);
            $display(" got r %h g %h clk %b row %0d lat %b oe %b",
                     rsp.red_lines, rsp.green_lines, rsp.shift_clock, rsp.row_address,
                     rsp.latch_pulse, rsp.output_enable);
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_fill_frame();
    test_directed_patterns();
    test_scan_settings();
    test_quiet_tail();
    wait_idle();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && pin_queue.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: files.f
sv/lmqs_pkg.sv
sv/lmqs_front.sv
sv/lmqs_queue.sv
sv/lmqs_back.sv
sv/led_matrix_quarter_scan_driver.sv
dv/tb.sv
